FILE: sv/avsue_pkg.sv
package avsue_pkg;

   localparam logic [7:0]  TYPE_SEQ_HDR  = 8'hB0;
   localparam logic [7:0]  TYPE_SEQ_END  = 8'hB1;
   localparam logic [7:0]  TYPE_PIC_I    = 8'hB2;
   localparam logic [7:0]  TYPE_EXT      = 8'hB5;
   localparam logic [23:0] START_CODE    = 24'h000001;
   localparam logic [23:0] PSEUDO_LIMIT  = 24'd4;
   localparam logic [23:0] OVF_WIN_TOP   = 24'hFF0000;
   localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;
   localparam logic [15:0] HDR_LEN       = 16'd4;
   localparam logic [1:0]  HOLD_FULL     = 2'd2;
   localparam int unsigned RSP_DEPTH     = 3;

   // one result beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       unit_start;
      logic       unit_end;
      logic       overflow;
      logic       stream_done;
      logic       last;
   } rsp_type;

   // outcome of pushing one payload byte through the window and bit packer
   typedef struct packed {
      logic [23:0] win;
      logic [14:0] acc;
      logic [2:0]  cnt;
      logic        emit;
      logic [7:0]  data;
   } commit_type;

endpackage

FILE: sv/avs_unit_extractor.sv
// avs_unit_extractor: splits a raw video byte stream into units and strips
// pseudo start code bits from the unit payload.
//
// req_*: one stream byte per beat; req_tuser marks an end-of-stream beat whose
//   byte is ignored. rsp_*: result beats; tuser carries the unit/status flags,
//   rsp_tlast marks the final result of the request beat that caused it.
// csr_*: writes the unit length limit (16 bit, counts the four start code
//   bytes); write only while the block is idle.
//
// A byte is taken every cycle while the result buffer keeps req_tready high.
// Payload bytes wait in a two-byte hold; a result is registered and shows up on
// rsp in the cycle after the beat that releases it. Most beats give zero or one
// result; an end-of-stream beat gives up to three, and req_tready stays low until the last of them is being taken.
// The three-entry result buffer sets the rate: a new beat is taken when the
// buffer is empty or its last entry leaves in the same cycle, so a stalled
// receiver stalls req after at most one pending result.
// Reset (synchronous) empties the buffer, restarts the start code search and
// sets the limit to 65535. An end-of-stream beat returns all state but the
// limit and the result buffer to its reset values.
module avs_unit_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_byte
   output logic [4:0]  rsp_tuser,   // [0] byte_valid [1] unit_start [2] unit_end
                                    // [3] overflow [4] stream_done
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic        searching_ff, searching_in;
   logic        type_pend_ff, type_pend_in;
   logic [7:0]  hold_ff [2];
   logic [7:0]  hold_in [2];
   logic [1:0]  hold_cnt_ff, hold_cnt_in;
   logic [23:0] win_ff, win_in;
   logic [14:0] acc_ff, acc_in;
   logic [2:0]  bit_cnt_ff, bit_cnt_in;
   logic        removal_ff, removal_in;
   logic [15:0] unit_len_ff, unit_len_in;
   logic [15:0] max_len_ff;

   avsue_pkg::rsp_type res_ff  [avsue_pkg::RSP_DEPTH];
   avsue_pkg::rsp_type res_in  [avsue_pkg::RSP_DEPTH];
   avsue_pkg::rsp_type res_new [avsue_pkg::RSP_DEPTH];
   logic [1:0]  rcnt_ff, rcnt_in;
   logic [1:0]  n_res;

   avsue_pkg::commit_type c1, c2;
   logic [1:0]  k;
   logic [15:0] len;
   logic        ovf;
   logic [14:0] acc_e;
   logic [2:0]  cnt_e;
   logic [23:0] win_shift;
   logic        req_fire, rsp_fire;

   function automatic avsue_pkg::commit_type commit_byte(input logic [23:0] win,
                                                         input logic [14:0] acc,
                                                         input logic [2:0]  cnt,
                                                         input logic        removal,
                                                         input logic [7:0]  b);
      avsue_pkg::commit_type r;
      logic [3:0] c;
      r.win = {win[15:0], b};
      if (r.win < avsue_pkg::PSEUDO_LIMIT && removal) begin
         r.acc = {acc[8:0], b[7:2]};
         c = {1'b0, cnt} + 4'd6;
      end else begin
         r.acc = {acc[6:0], b};
         c = {1'b0, cnt} + 4'd8;
      end
      r.emit = c[3];
      r.data = '0;
      if (c[3]) begin
         r.data = 8'(r.acc >> (c - 4'd8));
         c = c - 4'd8;
      end
      r.cnt = c[2:0];
      return r;
   endfunction

   function automatic avsue_pkg::rsp_type push_rsp(input logic [7:0] data,
                                                   input logic over,
                                                   input logic end_flag,
                                                   input logic done);
      avsue_pkg::rsp_type r;
      r.unit_start  = 1'b0;
      r.stream_done = done;
      r.last        = 1'b0;
      if (over) begin
         r.data_byte  = '0;
         r.byte_valid = 1'b0;
         r.unit_end   = 1'b1;
         r.overflow   = 1'b1;
      end else begin
         r.data_byte  = data;
         r.byte_valid = 1'b1;
         r.unit_end   = end_flag;
         r.overflow   = 1'b0;
      end
      return r;
   endfunction

   // leftover bits are zero-padded; the padded byte goes out only if nonzero
   function automatic avsue_pkg::rsp_type close_rsp(input logic [14:0] acc,
                                                    input logic [2:0]  cnt,
                                                    input logic        over,
                                                    input logic        done);
      avsue_pkg::rsp_type r;
      logic [7:0] pb;
      pb = 8'(acc << (4'd8 - {1'b0, cnt}));
      if (cnt != '0 && pb != '0) begin
         r = push_rsp(pb, over, 1'b1, done);
      end else begin
         r = '0;
         r.unit_end    = 1'b1;
         r.stream_done = done;
      end
      return r;
   endfunction

   assign req_tready = (rcnt_ff == 2'd0) || (rcnt_ff == 2'd1 && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rcnt_ff != 2'd0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tdata = res_ff[0].data_byte;
   assign rsp_tuser = {res_ff[0].stream_done, res_ff[0].overflow, res_ff[0].unit_end,
                       res_ff[0].unit_start, res_ff[0].byte_valid};
   assign rsp_tlast = res_ff[0].last;

   assign win_shift = {win_ff[15:0], req_tdata};

   always_comb begin
      searching_in = searching_ff;
      type_pend_in = type_pend_ff;
      hold_in      = hold_ff;
      hold_cnt_in  = hold_cnt_ff;
      win_in       = win_ff;
      acc_in       = acc_ff;
      bit_cnt_in   = bit_cnt_ff;
      removal_in   = removal_ff;
      unit_len_in  = unit_len_ff;
      res_new      = '{default: '0};
      n_res        = '0;
      k            = '0;
      len          = unit_len_ff;
      ovf          = 1'b0;
      acc_e        = acc_ff;
      cnt_e        = bit_cnt_ff;

      c1 = commit_byte(win_ff, acc_ff, bit_cnt_ff, removal_ff, hold_ff[0]);
      c2 = commit_byte(c1.win, c1.acc, c1.cnt, removal_ff, hold_ff[1]);

      if (req_fire) begin
         if (req_tuser) begin
            if (!searching_ff && !type_pend_ff) begin
               // drain the hold, then close the unit
               if (hold_cnt_ff != 2'd0) begin
                  acc_e = c1.acc;
                  cnt_e = c1.cnt;
                  if (c1.emit) begin
                     res_new[k] = push_rsp(c1.data, len >= max_len_ff, 1'b0, 1'b0);
                     if (len >= max_len_ff) begin
                        ovf = 1'b1;
                     end else begin
                        len = len + 16'd1;
                     end
                     k = k + 2'd1;
                  end
               end
               if (hold_cnt_ff == avsue_pkg::HOLD_FULL && !ovf) begin
                  acc_e = c2.acc;
                  cnt_e = c2.cnt;
                  if (c2.emit) begin
                     res_new[k] = push_rsp(c2.data, len >= max_len_ff, 1'b0, 1'b0);
                     if (len >= max_len_ff) begin
                        ovf = 1'b1;
                     end else begin
                        len = len + 16'd1;
                     end
                     k = k + 2'd1;
                  end
               end
               if (ovf) begin
                  res_new[k - 2'd1].stream_done = 1'b1;
                  n_res = k;
               end else begin
                  res_new[k] = close_rsp(acc_e, cnt_e, len >= max_len_ff, 1'b1);
                  n_res = k + 2'd1;
               end
            end else begin
               res_new[0].stream_done = 1'b1;
               n_res = 2'd1;
            end
            searching_in = 1'b1;
            type_pend_in = 1'b0;
            hold_in      = '{default: '0};
            hold_cnt_in  = '0;
            win_in       = '0;
            acc_in       = '0;
            bit_cnt_in   = '0;
            removal_in   = 1'b1;
            unit_len_in  = '0;
         end else if (searching_ff) begin
            win_in = win_shift;
            if (win_shift == avsue_pkg::START_CODE) begin
               searching_in = 1'b0;
               type_pend_in = 1'b1;
            end
         end else if (type_pend_ff) begin
            type_pend_in = 1'b0;
            win_in       = win_shift;
            removal_in   = !(req_tdata == avsue_pkg::TYPE_SEQ_HDR ||
                             req_tdata == avsue_pkg::TYPE_PIC_I ||
                             req_tdata == avsue_pkg::TYPE_EXT);
            unit_len_in  = avsue_pkg::HDR_LEN;
            acc_in       = '0;
            bit_cnt_in   = '0;
            hold_cnt_in  = '0;
            res_new[0].data_byte  = req_tdata;
            res_new[0].byte_valid = 1'b1;
            res_new[0].unit_start = 1'b1;
            n_res = 2'd1;
            // sequence end closes the unit on its type byte
            if (req_tdata == avsue_pkg::TYPE_SEQ_END) begin
               res_new[0].unit_end = 1'b1;
               searching_in = 1'b1;
            end
         end else if (hold_cnt_ff == avsue_pkg::HOLD_FULL) begin
            if (hold_ff[0] == 8'd0 && hold_ff[1] == 8'd0 && req_tdata == 8'd1) begin
               // next start code: held zeros are dropped
               res_new[0]   = close_rsp(acc_ff, bit_cnt_ff, unit_len_ff >= max_len_ff, 1'b0);
               n_res        = 2'd1;
               hold_cnt_in  = '0;
               win_in       = avsue_pkg::START_CODE;
               type_pend_in = 1'b1;
               acc_in       = '0;
               bit_cnt_in   = '0;
            end else begin
               win_in     = c1.win;
               acc_in     = c1.acc;
               bit_cnt_in = c1.cnt;
               hold_in[0] = hold_ff[1];
               hold_in[1] = req_tdata;
               if (c1.emit) begin
                  res_new[0] = push_rsp(c1.data, unit_len_ff >= max_len_ff, 1'b0, 1'b0);
                  n_res = 2'd1;
                  if (unit_len_ff >= max_len_ff) begin
                     // abandon the unit, resume the search at the held bytes
                     searching_in = 1'b1;
                     win_in       = avsue_pkg::OVF_WIN_TOP | {8'd0, hold_ff[1], req_tdata};
                     hold_cnt_in  = '0;
                     acc_in       = '0;
                     bit_cnt_in   = '0;
                  end else begin
                     unit_len_in = unit_len_ff + 16'd1;
                  end
               end
            end
         end else begin
            hold_in[hold_cnt_ff[0]] = req_tdata;
            hold_cnt_in = hold_cnt_ff + 2'd1;
         end
      end

      if (n_res != 2'd0) begin
         res_new[n_res - 2'd1].last = 1'b1;
      end
   end

   always_comb begin
      res_in  = res_ff;
      rcnt_in = rcnt_ff;
      if (req_fire) begin
         res_in  = res_new;
         rcnt_in = n_res;
      end else if (rsp_fire) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         rcnt_in   = rcnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         searching_ff <= 1'b1;
         type_pend_ff <= 1'b0;
         hold_ff      <= '{default: '0};
         hold_cnt_ff  <= '0;
         win_ff       <= '0;
         acc_ff       <= '0;
         bit_cnt_ff   <= '0;
         removal_ff   <= 1'b1;
         unit_len_ff  <= '0;
         max_len_ff   <= avsue_pkg::MAX_LEN_RESET;
         rcnt_ff      <= '0;
      end else begin
         searching_ff <= searching_in;
         type_pend_ff <= type_pend_in;
         hold_ff      <= hold_in;
         hold_cnt_ff  <= hold_cnt_in;
         win_ff       <= win_in;
         acc_ff       <= acc_in;
         bit_cnt_ff   <= bit_cnt_in;
         removal_ff   <= removal_in;
         unit_len_ff  <= unit_len_in;
         rcnt_ff      <= rcnt_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic       eos;
      logic [7:0] value;
   } stream_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'h0000;

   avs_unit_extractor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   logic [15:0]        len_limit = avsue_pkg::MAX_LEN_RESET;
   logic               hunting = 1'b1;
   logic               awaiting_type = 1'b0;
   logic [7:0]         hold [2] = '{8'h00, 8'h00};
   logic [1:0]         hold_fill = 2'd0;
   logic [23:0]        window = 24'h0;
   logic [14:0]        bit_acc = 15'h0;
   logic [3:0]         bit_fill = 4'd0;
   logic               strip_on = 1'b1;
   logic [15:0]        unit_len = 16'd0;
   logic               overran;
   avsue_pkg::rsp_type step_out [4];
   int                 step_n;
   avsue_pkg::rsp_type results_due [$];

   function automatic void clear_unit_state();
      hunting = 1'b1;
      awaiting_type = 1'b0;
      hold[0] = 8'h00;
      hold[1] = 8'h00;
      hold_fill = 2'd0;
      window = 24'h0;
      bit_acc = 15'h0;
      bit_fill = 4'd0;
      strip_on = 1'b1;
      unit_len = 16'd0;
   endfunction

   function automatic void emit_result(logic [7:0] data, logic valid, logic opens,
                                       logic closes, logic over, logic done);
      step_out[step_n] = '{data, valid, opens, closes, over, done, 1'b0};
      step_n++;
   endfunction

   function automatic void emit_payload(logic [7:0] value, logic closes, logic done);
      if (unit_len >= len_limit) begin
         overran = 1'b1;
         emit_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, done);
      end else begin
         unit_len++;
         emit_result(value, 1'b1, 1'b0, closes, 1'b0, done);
      end
   endfunction

   // pseudo start code: while stripping is on, a byte whose three-byte window is below 4 drops the low two bits
   function automatic void pack_byte(logic [7:0] b);
      window = {window[15:0], b};
      if (window < avsue_pkg::PSEUDO_LIMIT && strip_on) begin
         bit_acc = {bit_acc[8:0], b[7:2]};
         bit_fill += 4'd6;
      end else begin
         bit_acc = {bit_acc[6:0], b};
         bit_fill += 4'd8;
      end
      if (bit_fill >= 4'd8) begin
         bit_fill -= 4'd8;
         emit_payload(8'(bit_acc >> bit_fill), 1'b0, 1'b0);
      end
   endfunction

   function automatic void finish_unit(logic done);
      logic [3:0] cnt;
      logic [7:0] pad;
      cnt = bit_fill;
      pad = 8'h00;
      bit_fill = 4'd0;
      if (cnt > 4'd0 && cnt < 4'd8)
         pad = 8'(bit_acc << (4'd8 - cnt));
      bit_acc = 15'h0;
      if (pad != 8'h00)
         emit_payload(pad, 1'b1, done);
      else
         emit_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, done);
   endfunction

   function automatic void extract_step(logic [7:0] b, logic eos);
      step_n = 0;
      overran = 1'b0;
      if (eos) begin
         if (!hunting && !awaiting_type) begin
            for (int i = 0; i < hold_fill && !overran; i++)
               pack_byte(hold[i]);
            if (overran)
               step_out[step_n - 1].stream_done = 1'b1;
            else
               finish_unit(1'b1);
         end else begin
            emit_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
         end
         clear_unit_state();
      end else if (hunting) begin
         window = {window[15:0], b};
         if (window == avsue_pkg::START_CODE) begin
            hunting = 1'b0;
            awaiting_type = 1'b1;
         end
      end else if (awaiting_type) begin
         awaiting_type = 1'b0;
         window = {window[15:0], b};
         strip_on = !(b == avsue_pkg::TYPE_SEQ_HDR || b == avsue_pkg::TYPE_PIC_I ||
                      b == avsue_pkg::TYPE_EXT);
         unit_len = avsue_pkg::HDR_LEN;
         bit_acc = 15'h0;
         bit_fill = 4'd0;
         hold_fill = 2'd0;
         if (b == avsue_pkg::TYPE_SEQ_END) begin
            emit_result(b, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
            hunting = 1'b1;
         end else begin
            emit_result(b, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
         end
      end else if (hold_fill == avsue_pkg::HOLD_FULL) begin
         if ({hold[0], hold[1], b} == avsue_pkg::START_CODE) begin
            finish_unit(1'b0);
            hold_fill = 2'd0;
            window = avsue_pkg::START_CODE;
            awaiting_type = 1'b1;
         end else begin
            pack_byte(hold[0]);
            if (overran) begin
               // unit abandoned; the search resumes over the held bytes
               hunting = 1'b1;
               window = avsue_pkg::OVF_WIN_TOP | {8'h00, hold[1], b};
               hold_fill = 2'd0;
               bit_acc = 15'h0;
               bit_fill = 4'd0;
            end else begin
               hold[0] = hold[1];
               hold[1] = b;
            end
         end
      end else begin
         hold[hold_fill[0]] = b;
         hold_fill++;
      end
      if (step_n > 0)
         step_out[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++)
         results_due.push_back(step_out[i]);
   endfunction

   // ------------------------------------------------------- sampling at edges
   int                 failures = 0;
   int                 items_queued = 0;
   int                 items_taken = 0;
   logic               beat_taken = 1'b0;
   avsue_pkg::rsp_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("result beat with none expected: data_byte %0h tuser %0h",
                      rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata !== want.data_byte) begin
                  $error("data_byte: expected %0h, got %0h", want.data_byte, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser[0] !== want.byte_valid) begin
                  $error("byte_valid: expected %0b, got %0b", want.byte_valid, rsp_tuser[0]);
                  failures++;
               end
               if (rsp_tuser[1] !== want.unit_start) begin
                  $error("unit_start: expected %0b, got %0b", want.unit_start, rsp_tuser[1]);
                  failures++;
               end
               if (rsp_tuser[2] !== want.unit_end) begin
                  $error("unit_end: expected %0b, got %0b", want.unit_end, rsp_tuser[2]);
                  failures++;
               end
               if (rsp_tuser[3] !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_tuser[3]);
                  failures++;
               end
               if (rsp_tuser[4] !== want.stream_done) begin
                  $error("stream_done: expected %0b, got %0b", want.stream_done, rsp_tuser[4]);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            extract_step(req_tdata, req_tuser);
            beat_taken = 1'b1;
            items_taken++;
         end
         if (csr_valid && csr_ready)
            len_limit = csr_data;
      end
   end

   // ------------------------------------------------------------ byte sender
   stream_beat_type stream_bytes [$];
   stream_beat_type next_beat;
   logic            sender_gaps = 1'b1;
   int              burst_left = 0;
   int              gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beat_taken) begin
         beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (stream_bytes.size() > 0) begin
            next_beat = stream_bytes.pop_front();
            req_tdata <= next_beat.value;
            req_tuser <= next_beat.eos;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = sender_gaps ? $urandom_range(1, 6) : 0;
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------ result back-pressure
   logic        receiver_stalls = 1'b1;
   logic [15:0] stall_bits = 16'h0f35;
   logic [5:0]  stall_age = 6'd0;

   always @(negedge clock) begin
      stall_age = stall_age + 6'd1;
      if (stall_age == 6'd0)
         stall_bits = 16'($urandom) | 16'h0001;
      else
         stall_bits = {stall_bits[0], stall_bits[15:1]};
      rsp_tready <= !receiver_stalls || stall_bits[0];
   end

   // --------------------------------------------------------------- stimulus
   function automatic void add_beat(logic [7:0] value, logic eos);
      stream_bytes.push_back('{eos, value});
      items_queued++;
   endfunction

   // zero-heavy so that pseudo start codes and real start codes turn up
   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return 8'h00;
      else if (r < 6)
         return 8'($urandom_range(1, 3));
      else
         return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] unit_type();
      case ($urandom_range(0, 9))
         0:       return avsue_pkg::TYPE_SEQ_HDR;
         1:       return avsue_pkg::TYPE_SEQ_END;
         2:       return avsue_pkg::TYPE_PIC_I;
         3:       return avsue_pkg::TYPE_EXT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_random_traffic();
      int kind;
      int len;
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
         // broken start code
         add_beat(8'h00, 1'b0);
         add_beat(8'h00, 1'b0);
         add_beat(8'($urandom_range(2, 255)), 1'b0);
      end else if (kind == 1) begin
         add_beat(8'($urandom_range(0, 255)), 1'b1);
      end else if (kind == 2) begin
         add_beat(8'h00, 1'b0);
         add_beat(8'h00, 1'b0);
         add_beat(8'h01, 1'b0);
         add_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) add_beat(payload_byte(), 1'b0);
         add_beat(8'h00, 1'b0);
         add_beat(8'h00, 1'b0);
         add_beat(8'h01, 1'b0);
         add_beat(unit_type(), 1'b0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 28) : $urandom_range(0, 10);
         repeat (len) add_beat(payload_byte(), 1'b0);
         if ($urandom_range(0, 5) == 0)
            add_beat(8'($urandom_range(0, 255)), 1'b1);
      end
   endfunction

   task automatic wait_idle();
      while (items_taken != items_queued || results_due.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] phase_limit [6];
      int          base;
      phase_limit = '{16'd4, 16'd9, avsue_pkg::MAX_LEN_RESET, 16'd14, 16'd5, 16'd0};
      phase_limit[5] = 16'($urandom_range(4, 24));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: end of stream while searching, sequence end, pseudo start
      // code with padding, start code closing a unit, removal off, end of
      // stream inside a unit, end of stream while waiting for the type
      add_beat(8'hff, 1'b1);
      add_beat(8'h00, 1'b0); add_beat(8'h00, 1'b0); add_beat(8'h01, 1'b0);
      add_beat(avsue_pkg::TYPE_SEQ_END, 1'b0);
      add_beat(8'h00, 1'b0); add_beat(8'h00, 1'b0); add_beat(8'h01, 1'b0);
      add_beat(8'h40, 1'b0);
      add_beat(8'h00, 1'b0); add_beat(8'h00, 1'b0); add_beat(8'h02, 1'b0);
      add_beat(8'hff, 1'b0);
      add_beat(8'h00, 1'b0); add_beat(8'h00, 1'b0); add_beat(8'h01, 1'b0);
      add_beat(avsue_pkg::TYPE_SEQ_HDR, 1'b0);
      add_beat(8'hff, 1'b0); add_beat(8'h80, 1'b0);
      add_beat(8'h00, 1'b1);
      add_beat(8'h00, 1'b0); add_beat(8'h00, 1'b0); add_beat(8'h01, 1'b0);
      add_beat(8'h5a, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         sender_gaps = (phase != 2 && phase != 4);
         receiver_stalls = (phase != 2 && phase != 3);
         write_limit(phase_limit[phase]);
         base = items_queued;
         while (items_queued - base < 57)
            add_random_traffic();
         wait_idle();
      end

      repeat (20) @(negedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
sv/avsue_pkg.sv
sv/avs_unit_extractor.sv
tb/sv/testbench.sv
